// ===== hdl/square_matrix_add_multiply_defines.svh =====
// Assertion helpers for the matrix add and multiply block.
// Both sample on the rising clock edge and are disabled during reset.
`ifndef SQUARE_MATRIX_ADD_MULTIPLY_DEFINES_SVH
`define SQUARE_MATRIX_ADD_MULTIPLY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMAM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMAM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/smam_pkg.sv =====
package smam_pkg;

   localparam int DIM     = 3;
   localparam int DEPTH   = DIM * DIM;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W   = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int K_W     = $clog2(DIM + 1);

   localparam int ROW_W   = 3;
   localparam int VALUE_W = 16;
   localparam int SUM_W   = 17;
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 35;

   // flat row-major address of one matrix element
   function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] col);
      int flat;
      flat = int'(row) * DIM + int'(col);
      return ADDR_W'(flat);
   endfunction

   function automatic logic in_range(input logic [ROW_W-1:0] row,
                                     input logic [ROW_W-1:0] col);
      return (int'(row) < DIM) && (int'(col) < DIM);
   endfunction

endpackage

// ===== hdl/smam_if.sv =====
interface smam_req_if import smam_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [ROW_W-1:0]          row;
   logic [ROW_W-1:0]          col;
   logic signed [VALUE_W-1:0] value;
   logic                      go;

   modport source (output valid, op, row, col, value, go, input ready);
   modport sink   (input valid, op, row, col, value, go, output ready);
endinterface

interface smam_rsp_if import smam_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ROW_W-1:0]         out_row;
   logic [ROW_W-1:0]         out_col;
   logic signed [SUM_W-1:0]  sum_entry;
   logic signed [PROD_W-1:0] product_entry;
   logic                     last;

   modport source (output valid, out_row, out_col, sum_entry, product_entry, last,
                   input ready);
   modport sink   (input valid, out_row, out_col, sum_entry, product_entry, last,
                   output ready);
endinterface

// ===== hdl/smam_ram.sv =====
module smam_ram #(
   parameter int  WIDTH  = 16,
   parameter int  DEPTH  = 9,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/square_matrix_add_multiply.sv =====
// Load words are taken whenever ready is high; ready is high whenever no run is in progress.
// A go word starts a run of DIM*DIM results in row-major order; each entry steps through
// the run, wait and send states, and the next entry starts only once the output accepts it.
// Entries are computed one at a time by the single shared multiply-accumulate unit fed
// from one read port on each matrix RAM. Synchronous active-high reset returns
// the sequencer to idle; matrix contents are not cleared.
`include "square_matrix_add_multiply_defines.svh"

module square_matrix_add_multiply import smam_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   smam_req_if.sink   req_chan,
   smam_rsp_if.source rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_SEND = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] c_ff, c_in;
   logic [K_W-1:0]   k_ff, k_in;

   logic s1_valid_ff, s1_valid_in;
   logic s1_sum_ff, s1_sum_in;
   logic s2_valid_ff, s2_valid_in;
   logic done_ff, done_in;

   logic signed [MUL_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   logic                      req_accept, rsp_accept, go_accept;
   logic                      k_is_sum, last_entry, acc_clear;
   logic [ADDR_W-1:0]         wr_addr, a_rd_addr, b_rd_addr;
   logic                      a_wr_en, b_wr_en;
   logic signed [VALUE_W-1:0] a_rd, b_rd;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_accept = rsp_chan.valid && rsp_chan.ready;
   assign go_accept  = req_accept && req_chan.go;
   assign k_is_sum   = (k_ff == K_W'(DIM));
   assign last_entry = (r_ff == IDX_W'(DIM - 1)) && (c_ff == IDX_W'(DIM - 1));

   // element stores
   assign wr_addr = addr_of(req_chan.row, req_chan.col);
   assign a_wr_en = req_accept && !req_chan.op && in_range(req_chan.row, req_chan.col);
   assign b_wr_en = req_accept && req_chan.op && in_range(req_chan.row, req_chan.col);

   // walk A along the row and B down the column, then fetch the pair for the sum
   always_comb begin
      if (k_is_sum) begin
         a_rd_addr = addr_of(ROW_W'(r_ff), ROW_W'(c_ff));
         b_rd_addr = addr_of(ROW_W'(r_ff), ROW_W'(c_ff));
      end else begin
         a_rd_addr = addr_of(ROW_W'(r_ff), ROW_W'(k_ff));
         b_rd_addr = addr_of(ROW_W'(k_ff), ROW_W'(c_ff));
      end
   end

   smam_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.value),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd)
   );

   smam_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.value),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go_accept) begin
               state_in = ST_RUN;
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            k_in = k_ff + K_W'(1);
            if (k_is_sum) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (done_ff) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_accept) begin
               if (last_entry) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  k_in     = '0;
                  if (c_ff == IDX_W'(DIM - 1)) begin
                     c_in = '0;
                     r_in = r_ff + IDX_W'(1);
                  end else begin
                     c_in = c_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // shared multiply-accumulate pipeline: read, multiply, accumulate
   assign acc_clear   = (state_ff != ST_RUN) && (state_in == ST_RUN);
   assign s1_valid_in = (state_ff == ST_RUN);
   assign s1_sum_in   = k_is_sum;
   assign s2_valid_in = s1_valid_ff && !s1_sum_ff;
   assign done_in     = s1_valid_ff && s1_sum_ff;
   assign prod_in     = a_rd * b_rd;
   assign sum_in      = (s1_valid_ff && s1_sum_ff) ? (SUM_W'(a_rd) + SUM_W'(b_rd)) : sum_ff;

   always_comb begin
      if (acc_clear) begin
         acc_in = '0;
      end else if (s2_valid_ff) begin
         acc_in = acc_ff + PROD_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         r_ff        <= '0;
         c_ff        <= '0;
         k_ff        <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         r_ff        <= r_in;
         c_ff        <= c_in;
         k_ff        <= k_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sum_ff <= s1_sum_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      sum_ff    <= sum_in;
   end

   // outputs
   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = (state_ff == ST_SEND);
   assign rsp_chan.out_row       = ROW_W'(r_ff);
   assign rsp_chan.out_col       = ROW_W'(c_ff);
   assign rsp_chan.sum_entry     = sum_ff;
   assign rsp_chan.product_entry = acc_ff;
   assign rsp_chan.last          = last_entry;

   `SMAM_ASSERT_NOW(a_no_overlap, 1'b1, !(req_chan.ready && rsp_chan.valid), "ready during a run")
   `SMAM_ASSERT_NEXT(a_go_starts, go_accept, state_ff == ST_RUN && k_ff == '0, "run did not start")
   `SMAM_ASSERT_NEXT(a_last_idle, rsp_accept && last_entry, req_chan.ready, "not idle after last")
   `SMAM_ASSERT_NOW(a_send_done, rsp_chan.valid, !s1_valid_ff && !s2_valid_ff, "pipe not empty")

endmodule

// ===== verif/square_matrix_add_multiply_tb.sv =====
module square_matrix_add_multiply_tb import smam_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic OP_A      = 1'b0;
   localparam logic OP_B      = 1'b1;
   localparam logic LOAD_ONLY = 1'b0;
   localparam logic RUN       = 1'b1;

   localparam int RANDOM_WORDS = 185;
   localparam int LIMIT_CYCLES = 400000;
   localparam int TAIL_CYCLES  = 4 * (DIM + 4);

   typedef struct packed {
      logic [ROW_W-1:0]         out_row;
      logic [ROW_W-1:0]         out_col;
      logic signed [SUM_W-1:0]  sum_entry;
      logic signed [PROD_W-1:0] product_entry;
      logic                     last;
   } matrix_entry_type;

   logic clock;
   logic reset;

   smam_req_if req_chan ();
   smam_rsp_if rsp_chan ();

   square_matrix_add_multiply dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic signed [VALUE_W-1:0] mat_a [DEPTH];
   logic signed [VALUE_W-1:0] mat_b [DEPTH];
   matrix_entry_type          pending_entries [$];
   matrix_entry_type          due;
   bit                        failed;
   bit                        gaps_on;
   bit                        stalls_on;
   int                        ready_hold;
   int                        cycle_count;
   int                        random_sent;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 16'sh8000;
      if (roll < 20) return 16'sh7fff;
      if (roll < 25) return '0;
      if (roll < 30) return '1;
      return VALUE_W'($urandom());
   endfunction

   // store the word, then on go compute every sum and product entry in row-major order
   function automatic void absorb_word(logic op, logic [ROW_W-1:0] row,
                                       logic [ROW_W-1:0] col,
                                       logic signed [VALUE_W-1:0] value, logic go);
      matrix_entry_type entry;
      longint           acc;
      if (int'(row) < DIM && int'(col) < DIM) begin
         if (op == OP_B) mat_b[int'(row) * DIM + int'(col)] = value;
         else            mat_a[int'(row) * DIM + int'(col)] = value;
      end
      if (go != RUN) return;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            acc = 0;
            for (int k = 0; k < DIM; k++)
               acc += longint'(mat_a[r * DIM + k]) * longint'(mat_b[k * DIM + c]);
            entry.out_row       = ROW_W'(r);
            entry.out_col       = ROW_W'(c);
            entry.sum_entry     = SUM_W'(longint'(mat_a[r * DIM + c]) +
                                         longint'(mat_b[r * DIM + c]));
            entry.product_entry = acc[PROD_W-1:0];
            entry.last          = (r == DIM - 1) && (c == DIM - 1);
            pending_entries.push_back(entry);
         end
      end
   endfunction

   function automatic void match_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         absorb_word(req_chan.op, req_chan.row, req_chan.col, req_chan.value, req_chan.go);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_entries.size() == 0) begin
            $display("%0t: unexpected entry row %0d col %0d", $time,
                     rsp_chan.out_row, rsp_chan.out_col);
            failed = 1'b1;
         end else begin
            due = pending_entries.pop_front();
            match_field("out_row", due.out_row, rsp_chan.out_row);
            match_field("out_col", due.out_col, rsp_chan.out_col);
            match_field("sum_entry", due.sum_entry, rsp_chan.sum_entry);
            match_field("product_entry", due.product_entry, rsp_chan.product_entry);
            match_field("last", due.last, rsp_chan.last);
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stalls_on && ready_hold > 0) begin
         ready_hold--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (stalls_on && $urandom_range(0, 99) < 25) ready_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("square_matrix_add_multiply_tb: FAIL");
         $finish;
      end
   end

   // returns at the edge where the word is taken; valid stays up for the next call
   task automatic send_word(logic op, logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                            logic signed [VALUE_W-1:0] value, logic go);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.row   <= row;
      req_chan.col   <= col;
      req_chan.value <= value;
      req_chan.go    <= go;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_entries.size() != 0) @(posedge clock);
   endtask

   // both matrices full of the most negative value: largest positive products
   task automatic test_fill_extremes();
      for (int i = 0; i < DEPTH; i++)
         send_word(OP_A, ROW_W'(i / DIM), ROW_W'(i % DIM), 16'sh8000, LOAD_ONLY);
      for (int i = 0; i < DEPTH; i++)
         send_word(OP_B, ROW_W'(i / DIM), ROW_W'(i % DIM), 16'sh8000,
                   (i == DEPTH - 1) ? RUN : LOAD_ONLY);
   endtask

   // go on a word whose index is off the matrix: nothing stored, run still comes out
   task automatic test_out_of_range();
      send_word(OP_B, 3'd7, 3'd7, 16'sh7fff, RUN);
   endtask

   task automatic test_mixed_signs();
      send_word(OP_A, 3'd0, 3'd0, 16'sh7fff, LOAD_ONLY);
      send_word(OP_B, 3'd0, 3'd7, 16'sh7fff, LOAD_ONLY);
      send_word(OP_B, ROW_W'(DIM - 1), ROW_W'(DIM - 1), 16'sh7fff, LOAD_ONLY);
      send_word(OP_A, ROW_W'(DIM - 1), 3'd0, '1, RUN);
   endtask

   task automatic test_random_runs();
      int loads;
      while (random_sent < RANDOM_WORDS) begin
         gaps_on   = $urandom_range(0, 99) >= 20;
         stalls_on = $urandom_range(0, 99) >= 20;
         loads = $urandom_range(0, 2 * DEPTH);
         repeat (loads) begin
            if ($urandom_range(0, 99) < 85)
               send_word(1'($urandom_range(0, 1)), ROW_W'($urandom_range(0, DIM - 1)),
                         ROW_W'($urandom_range(0, DIM - 1)), pick_value(), LOAD_ONLY);
            else
               send_word(1'($urandom_range(0, 1)), ROW_W'($urandom_range(0, 7)),
                         ROW_W'($urandom_range(0, 7)), pick_value(), LOAD_ONLY);
            random_sent++;
         end
         if ($urandom_range(0, 99) < 80)
            send_word(1'($urandom_range(0, 1)), ROW_W'($urandom_range(0, DIM - 1)),
                      ROW_W'($urandom_range(0, DIM - 1)), pick_value(), RUN);
         else
            send_word(1'($urandom_range(0, 1)), ROW_W'($urandom_range(0, 7)),
                      ROW_W'($urandom_range(0, 7)), pick_value(), RUN);
         random_sent++;
         if ($urandom_range(0, 99) < 10) wait_drained();
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op    <= OP_A;
      req_chan.row   <= '0;
      req_chan.col   <= '0;
      req_chan.value <= '0;
      req_chan.go    <= LOAD_ONLY;
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_fill_extremes();
      test_out_of_range();
      test_mixed_signs();
      // hold the sender until every entry has come back
      wait_drained();
      test_random_runs();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!failed)
         $display("square_matrix_add_multiply_tb: PASS");
      else
         $display("square_matrix_add_multiply_tb: FAIL");
      $finish;
   end

endmodule
